// File: rtl/bqe_pkg.sv
// bqe_pkg: shared widths, codes and handshake structs of the biquad cascade equalizer
// no dependencies; imported by every module of the block

package bqe_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int COEF_W           = 32;
    localparam int COEF_FRAC        = 28;
    localparam int HIST_W           = 48;
    localparam int FRAC_BITS        = 24;
    localparam int COEFS_PER_STAGE  = 5;

    localparam int DEF_STAGE_LIMIT  = 8;
    localparam int DEF_MAX_CHANNELS = 2;

    localparam int CMD_W            = 2;
    localparam int STAGE_SEL_W      = 3;
    localparam int COEF_SEL_W       = 3;
    localparam int STAGE_COUNT_W    = 4;
    localparam int CFG_INDEX_W      = 1;
    localparam int CFG_DATA_W       = 4;

    localparam int S_TDATA_W        = 56;
    localparam int S_TUSER_W        = 2;
    localparam int M_TDATA_W        = 16;

    // product magnitude and accumulator widths
    localparam int MAG_W            = 53;
    localparam int ACC_W            = 56;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_COEF   = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STAGE_COUNT   = 1'b0,
        CFG_FILTER_ENABLE = 1'b1
    } t_cfg_reg;

    typedef enum logic [COEF_SEL_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_sel;

    typedef struct packed {
        logic                     start;
        logic signed [COEF_W-1:0] coef;
        logic signed [HIST_W-1:0] x;
    } t_mul_req;

    typedef struct packed {
        logic             done;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_mul_res;

endpackage

// File: rtl/bqe_ram.sv
// bqe_ram: generic single-port-write, single-port-read ram with registered read data
// uses bqe_pkg for its default size

module bqe_ram
    import bqe_pkg::*;
#(
    parameter int WIDTH = COEF_W,
    parameter int DEPTH = DEF_STAGE_LIMIT * COEFS_PER_STAGE
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bqe_cmul.sv
// bqe_cmul: Q4.28 by Q24.24 product, magnitude rounded half up, one shared 32x24 multiplier
// uses bqe_pkg; result ready after the HI, LO, RND and SUM steps that follow start

module bqe_cmul
    import bqe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_res o_res
);

    localparam int HALF_W   = HIST_W / 2;
    localparam int PROD_W   = COEF_W + HALF_W;
    localparam int RND_W    = PROD_W + 1;
    localparam int LOW_BITS = COEF_FRAC - HALF_W;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_HI,
        MS_LO,
        MS_RND,
        MS_SUM
    } t_mstate;

    t_mstate            r_state;
    logic [COEF_W-1:0]  r_cm;
    logic [HIST_W-1:0]  r_xm;
    logic               r_neg;
    logic [PROD_W-1:0]  r_ph;
    logic [PROD_W-1:0]  r_pl;
    logic [RND_W-1:0]   r_rnd;
    logic [MAG_W-1:0]   r_mag;
    logic               r_done;

    logic [COEF_W-1:0]  w_cm;
    logic [HIST_W-1:0]  w_xm;
    logic [HALF_W-1:0]  w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic [RND_W-1:0]   n_rnd;
    logic [MAG_W-1:0]   n_mag;

    always_comb begin
        w_cm    = i_req.coef[COEF_W-1] ? (~i_req.coef + COEF_W'(1)) : i_req.coef;
        w_xm    = i_req.x[HIST_W-1] ? (~i_req.x + HIST_W'(1)) : i_req.x;
        w_mul_b = (r_state == MS_HI) ? r_xm[HIST_W-1:HALF_W] : r_xm[HALF_W-1:0];
        w_prod  = PROD_W'(r_cm) * PROD_W'(w_mul_b);
        n_rnd   = RND_W'({r_ph[LOW_BITS-1:0], {HALF_W{1'b0}}}) + RND_W'(r_pl)
                + (RND_W'(1) << (COEF_FRAC - 1));
        n_mag   = MAG_W'(r_ph[PROD_W-1:LOW_BITS]) + MAG_W'(r_rnd[RND_W-1:COEF_FRAC]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                MS_IDLE: begin
                    if (i_req.start) begin
                        r_cm    <= w_cm;
                        r_xm    <= w_xm;
                        r_neg   <= i_req.coef[COEF_W-1] ^ i_req.x[HIST_W-1];
                        r_state <= MS_HI;
                    end
                end
                MS_HI: begin
                    r_ph    <= w_prod;
                    r_state <= MS_LO;
                end
                MS_LO: begin
                    r_pl    <= w_prod;
                    r_state <= MS_RND;
                end
                MS_RND: begin
                    r_rnd   <= n_rnd;
                    r_state <= MS_SUM;
                end
                MS_SUM: begin
                    r_mag   <= n_mag;
                    r_done  <= 1'b1;
                    r_state <= MS_IDLE;
                end
                default: begin
                    r_state <= MS_IDLE;
                end
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.neg  = r_neg;
    assign o_res.mag  = r_mag;

`ifndef SYNTHESIS
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == MS_IDLE))
        else $error("product started while unit busy");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> (r_state == MS_HI))
        else $error("start did not enter the multiply sequence");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");
`endif

endmodule

// File: rtl/biquad_cascade_equalizer.sv
// biquad_cascade_equalizer: top level, sequencer around coefficient and history rams
// uses bqe_pkg, bqe_ram and bqe_cmul
//
// Usage:
//   s_axis carries one item per handshake; tuser holds the command (sample, coefficient
//   write, history clear), tdata the remaining fields. m_axis returns one output sample
//   per sample item; coefficient writes and clears return nothing.
//   The cfg channel writes stage_count (index 0) and filter_enable (index 1); enabling
//   from the disabled state clears all history. cfg is always ready.
//   Each biquad stage needs five products (b0*x, b1*x, a1*y, b2*x, a2*y), computed one
//   after another on the single shared multiplier unit; a filtered sample passes through
//   the states MUL, WAIT and POST for each product, then PCM and OUT, and no new item is
//   taken until the block is back in IDLE. A pass-through sample goes straight to OUT;
//   a coefficient write or clear is done on acceptance.
//   Reset clears the state and configuration registers, marks all coefficients and history as zero through
//   valid bits (no clearing pass) and empties the output register.
//   A result waits in the output register while m_axis stalls; the block can take the next
//   item, but holds its result back and takes no more items until the register is free.

module biquad_cascade_equalizer
    import bqe_pkg::*;
#(
    parameter int STAGE_LIMIT  = DEF_STAGE_LIMIT,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // channel, sample_in[16:1], stage_index[19:17], coef_select[22:20], coef_value[54:23]
    input  logic [S_TDATA_W-1:0]   i_s_axis_tdata,
    // command
    input  logic [S_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // sample_out
    output logic [M_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int COEF_DEPTH = STAGE_LIMIT * COEFS_PER_STAGE;
    localparam int HIST_DEPTH = STAGE_LIMIT * MAX_CHANNELS;
    localparam int CADDR_W    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int HADDR_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int STAGE_W    = (STAGE_LIMIT > 1) ? $clog2(STAGE_LIMIT) : 1;
    localparam int NST_W      = $clog2(STAGE_LIMIT + 1);
    localparam int EXT_W      = HIST_W - SAMPLE_W - FRAC_BITS;

    localparam int OFS_CHAN   = 0;
    localparam int OFS_SAMPLE = OFS_CHAN + 1;
    localparam int OFS_STAGE  = OFS_SAMPLE + SAMPLE_W;
    localparam int OFS_SEL    = OFS_STAGE + STAGE_SEL_W;
    localparam int OFS_COEF   = OFS_SEL + COEF_SEL_W;

    localparam logic signed [ACC_W-1:0] ACC_HMAX =
        {{(ACC_W-HIST_W+1){1'b0}}, {(HIST_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_HMIN =
        {{(ACC_W-HIST_W+1){1'b1}}, {(HIST_W-1){1'b0}}};
    localparam logic signed [HIST_W-1:0] PCM_TOP =
        {{(EXT_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}, {FRAC_BITS{1'b0}}};
    localparam logic signed [HIST_W-1:0] PCM_BOT =
        {{(EXT_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}, {FRAC_BITS{1'b0}}};
    localparam logic [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [FRAC_BITS-1:0] FRAC_HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WAIT,
        ST_POST,
        ST_PCM,
        ST_OUT
    } t_state;

    // product order within a stage
    typedef enum logic [2:0] {
        STEP_B0X,
        STEP_B1X,
        STEP_A1Y,
        STEP_B2X,
        STEP_A2Y
    } t_step;

    function automatic t_step f_next_step(input t_step s);
        t_step r;
        unique case (s)
            STEP_B0X: r = STEP_B1X;
            STEP_B1X: r = STEP_A1Y;
            STEP_A1Y: r = STEP_B2X;
            STEP_B2X: r = STEP_A2Y;
            STEP_A2Y: r = STEP_B0X;
            default:  r = STEP_B0X;
        endcase
        return r;
    endfunction

    function automatic t_coef_sel f_step_coef(input t_step s);
        t_coef_sel r;
        unique case (s)
            STEP_B0X: r = COEF_B0;
            STEP_B1X: r = COEF_B1;
            STEP_A1Y: r = COEF_A1;
            STEP_B2X: r = COEF_B2;
            STEP_A2Y: r = COEF_A2;
            default:  r = COEF_A2;
        endcase
        return r;
    endfunction

    function automatic logic signed [HIST_W-1:0] f_sat(input logic signed [ACC_W-1:0] v);
        logic signed [HIST_W-1:0] r;
        priority if (v > ACC_HMAX) begin
            r = ACC_HMAX[HIST_W-1:0];
        end else if (v < ACC_HMIN) begin
            r = ACC_HMIN[HIST_W-1:0];
        end else begin
            r = v[HIST_W-1:0];
        end
        return r;
    endfunction

    t_state                      r_state;
    t_step                       r_step;
    logic [STAGE_W-1:0]          r_stage;
    logic [NST_W-1:0]            r_nst;
    logic                        r_ch;
    logic [STAGE_COUNT_W-1:0]    r_stage_count;
    logic                        r_enable;
    logic [COEF_DEPTH-1:0]       r_coef_valid;
    logic [HIST_DEPTH-1:0]       r_hist_valid;
    logic                        r_cv_q;
    logic                        r_hv_q;
    logic signed [HIST_W-1:0]    r_x;
    logic signed [HIST_W-1:0]    r_y;
    logic signed [HIST_W-1:0]    r_z1;
    logic signed [HIST_W-1:0]    r_z2;
    logic signed [HIST_W-1:0]    r_z1n;
    logic signed [ACC_W-1:0]     r_acc;
    logic [SAMPLE_W-1:0]         r_res;
    logic                        r_m_valid;
    logic [M_TDATA_W-1:0]        r_m_data;

    t_cmd                        w_cmd;
    logic                        w_chan;
    logic                        w_ch_eff;
    logic signed [SAMPLE_W-1:0]  w_sample;
    logic [STAGE_SEL_W-1:0]      w_stage_idx;
    logic [COEF_SEL_W-1:0]       w_coef_sel;
    logic [COEF_W-1:0]           w_coef_val;
    logic                        w_s_acc;
    logic                        w_cfg_acc;
    logic                        w_coef_legal;
    logic                        w_coef_we;
    logic [CADDR_W-1:0]          w_caddr_wr;
    logic [CADDR_W-1:0]          w_caddr_rd;
    logic [COEF_W-1:0]           w_coef_rdata;
    logic                        w_hist_we;
    logic [HADDR_W-1:0]          w_haddr_wr;
    logic [HADDR_W-1:0]          w_haddr_rd;
    logic [2*HIST_W-1:0]         w_hist_wdata;
    logic [2*HIST_W-1:0]         w_hist_rdata;
    t_step                       n_step;
    logic [STAGE_W-1:0]          n_stage_rd;
    logic                        w_last;
    logic signed [ACC_W-1:0]     w_base;
    logic [ACC_W-1:0]            w_term;
    logic signed [ACC_W-1:0]     n_acc;
    logic signed [HIST_W-1:0]    w_sat;
    logic                        w_round_up;
    logic [SAMPLE_W-1:0]         w_pcm;
    t_mul_req                    mul_req;
    t_mul_res                    mul_res;

    assign w_cmd       = t_cmd'(i_s_axis_tuser[CMD_W-1:0]);
    assign w_chan      = i_s_axis_tdata[OFS_CHAN];
    assign w_sample    = i_s_axis_tdata[OFS_STAGE-1:OFS_SAMPLE];
    assign w_stage_idx = i_s_axis_tdata[OFS_SEL-1:OFS_STAGE];
    assign w_coef_sel  = i_s_axis_tdata[OFS_COEF-1:OFS_SEL];
    assign w_coef_val  = i_s_axis_tdata[OFS_COEF+COEF_W-1:OFS_COEF];
    assign w_ch_eff    = (MAX_CHANNELS > 1) ? w_chan : 1'b0;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign w_cfg_acc       = i_cfg_valid && o_cfg_ready;

    always_comb begin
        w_coef_legal = (int'(w_stage_idx) < STAGE_LIMIT)
                    && (w_coef_sel < COEF_SEL_W'(COEFS_PER_STAGE));
        w_coef_we    = w_s_acc && (w_cmd == CMD_COEF) && w_coef_legal;
        w_caddr_wr   = CADDR_W'(int'(w_stage_idx) * COEFS_PER_STAGE + int'(w_coef_sel));

        n_step     = f_next_step(r_step);
        n_stage_rd = (r_step == STEP_A2Y) ? r_stage + STAGE_W'(1) : r_stage;
        w_last     = (r_step == STEP_A2Y) && ((NST_W'(r_stage) + NST_W'(1)) == r_nst);

        if (r_state == ST_IDLE) begin
            w_caddr_rd = CADDR_W'(int'(f_step_coef(STEP_B0X)));
            w_haddr_rd = HADDR_W'(w_ch_eff);
        end else begin
            w_caddr_rd = CADDR_W'(int'(n_stage_rd) * COEFS_PER_STAGE
                                  + int'(f_step_coef(n_step)));
            w_haddr_rd = HADDR_W'(int'(n_stage_rd) * MAX_CHANNELS + int'(r_ch));
        end

        w_sat        = f_sat(r_acc);
        w_hist_we    = (r_state == ST_POST) && (r_step == STEP_A2Y);
        w_haddr_wr   = HADDR_W'(int'(r_stage) * MAX_CHANNELS + int'(r_ch));
        w_hist_wdata = {w_sat, r_z1n};

        mul_req.start = (r_state == ST_MUL);
        mul_req.coef  = r_cv_q ? w_coef_rdata : '0;
        mul_req.x     = ((r_step == STEP_A1Y) || (r_step == STEP_A2Y)) ? r_y : r_x;

        unique case (r_step)
            STEP_B0X: w_base = ACC_W'(r_z1);
            STEP_B1X: w_base = ACC_W'(r_z2);
            STEP_B2X: w_base = '0;
            default:  w_base = r_acc;
        endcase
        w_term = ACC_W'(mul_res.mag);
        if (mul_res.neg ^ ((r_step == STEP_A1Y) || (r_step == STEP_A2Y))) begin
            n_acc = w_base - w_term;
        end else begin
            n_acc = w_base + w_term;
        end

        // round to nearest, ties to even, on the Q24.24 value
        w_round_up = (r_x[FRAC_BITS-1:0] > FRAC_HALF)
                  || ((r_x[FRAC_BITS-1:0] == FRAC_HALF) && r_x[FRAC_BITS]);
        priority if (r_x >= PCM_TOP) begin
            w_pcm = SMP_MAX;
        end else if (r_x <= PCM_BOT) begin
            w_pcm = SMP_MIN;
        end else begin
            w_pcm = r_x[FRAC_BITS+SAMPLE_W-1:FRAC_BITS] + SAMPLE_W'(w_round_up);
        end
    end

    bqe_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_caddr_wr),
        .i_wdata (w_coef_val),
        .i_raddr (w_caddr_rd),
        .o_rdata (w_coef_rdata)
    );

    bqe_ram #(
        .WIDTH (2 * HIST_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_haddr_wr),
        .i_wdata (w_hist_wdata),
        .i_raddr (w_haddr_rd),
        .o_rdata (w_hist_rdata)
    );

    bqe_cmul u_cmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_res   (mul_res)
    );

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        r_cv_q <= r_coef_valid[w_caddr_rd];
        r_hv_q <= r_hist_valid[w_haddr_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_step        <= STEP_B0X;
            r_stage       <= '0;
            r_stage_count <= '0;
            r_enable      <= 1'b0;
            r_coef_valid  <= '0;
            r_hist_valid  <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (w_cfg_acc) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_STAGE_COUNT: begin
                        r_stage_count <= i_cfg_data[STAGE_COUNT_W-1:0];
                    end
                    CFG_FILTER_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                        if (i_cfg_data[0] && !r_enable) begin
                            r_hist_valid <= '0;
                        end
                    end
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_s_acc) begin
                        unique case (w_cmd)
                            CMD_SAMPLE: begin
                                r_ch    <= w_ch_eff;
                                r_x     <= {{EXT_W{w_sample[SAMPLE_W-1]}}, w_sample,
                                            {FRAC_BITS{1'b0}}};
                                r_step  <= STEP_B0X;
                                r_stage <= '0;
                                r_nst   <= (32'(r_stage_count) > 32'(STAGE_LIMIT))
                                         ? NST_W'(STAGE_LIMIT) : NST_W'(r_stage_count);
                                if (r_enable && (r_stage_count != '0)) begin
                                    r_state <= ST_MUL;
                                end else begin
                                    r_res   <= w_sample;
                                    r_state <= ST_OUT;
                                end
                            end
                            CMD_COEF: begin
                                if (w_coef_legal) begin
                                    r_coef_valid[w_caddr_wr] <= 1'b1;
                                end
                            end
                            CMD_CLEAR: begin
                                r_hist_valid <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    if (r_step == STEP_B0X) begin
                        r_z1 <= r_hv_q ? w_hist_rdata[HIST_W-1:0] : '0;
                        r_z2 <= r_hv_q ? w_hist_rdata[2*HIST_W-1:HIST_W] : '0;
                    end
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mul_res.done) begin
                        r_acc   <= n_acc;
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    unique case (r_step)
                        STEP_B0X: r_y   <= w_sat;
                        STEP_A1Y: r_z1n <= w_sat;
                        STEP_A2Y: begin
                            r_x                      <= r_y;
                            r_hist_valid[w_haddr_wr] <= 1'b1;
                            r_stage                  <= n_stage_rd;
                        end
                        default: begin
                        end
                    endcase
                    r_step  <= n_step;
                    r_state <= w_last ? ST_PCM : ST_MUL;
                end
                ST_PCM: begin
                    r_res   <= w_pcm;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= r_res;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_res.done |-> (r_state == ST_WAIT))
        else $error("product finished outside the wait state");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == ST_OUT))
        else $error("output loaded outside the output state");

    a_stage_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_MUL) || (r_state == ST_WAIT) || (r_state == ST_POST))
            |-> (NST_W'(r_stage) < r_nst))
        else $error("stage counter ran past the active stage count");
`endif

endmodule
